>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, during reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/pve_pkg.sv
// Package with the types and constants of the prefix varint encoder.
`default_nettype none

package pve_pkg;

	localparam int BYTE_W    = 8;
	localparam int GROUP_W   = 7;
	localparam int VALUE_W   = 64;
	localparam int MAX_BYTES = 9;
	localparam int SEQ_W     = MAX_BYTES * BYTE_W;
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [CNT_W-1:0] nbytes;
	} enc_t;

endpackage

`default_nettype wire

>>> rtl/core/prefix_varint_encoder_unit.sv
// Top level of the prefix varint encoder with optional zigzag mapping.
// Usage:
//   The value channel (value_valid, value_ready, func, value) takes one 64-bit
//   value per beat; func high zigzag maps it as a signed number first.
//   The byte channel (byte_valid, byte_ready, out_byte, last_byte) gives the
//   encoding one byte per beat, header first, with last_byte high on the
//   final byte of each value.
//   A value accepted is held in the input register, then moves into the
//   output shift register, from which its first byte can be taken.
//   A value needs from one to nine byte beats; the single byte-wide output
//   shift register gives them out one byte at a time.
//   The next value is accepted while the current one is still shifting out,
//   so bytes leave back to back at one per cycle when the receiver is ready.
//   When the receiver stalls, the current byte holds, the input register
//   fills and value_ready drops until the shift register frees up.
//   Reset clears both valid flags; no bytes are pending after reset.
`default_nettype none

module prefix_varint_encoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          value_valid,
	output logic                          value_ready,
	input  logic                          func,
	input  logic [pve_pkg::VALUE_W-1:0]   value,
	output logic                          byte_valid,
	input  logic                          byte_ready,
	output logic [pve_pkg::BYTE_W-1:0]    out_byte,
	output logic                          last_byte
);
	import pve_pkg::*;

	logic               valid_s1;
	logic               func_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               valid_s2;
	logic [SEQ_W-1:0]   seq_s2;
	logic [CNT_W-1:0]   cnt_s2;
	enc_t               enc;
	logic               load_s2;
	logic               out_beat;

	pve_encode u_encode (
		.func  (func_s1),
		.value (value_s1),
		.enc   (enc)
	);

	assign out_beat    = valid_s2 && byte_ready;
	assign load_s2     = valid_s1 && (!valid_s2 || (out_beat && last_byte));
	assign value_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			cnt_s2   <= '0;
		end else begin
			if (value_ready) begin
				valid_s1 <= value_valid;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
				cnt_s2   <= enc.nbytes;
			end else if (out_beat) begin
				if (last_byte) begin
					valid_s2 <= 1'b0;
				end
				cnt_s2 <= cnt_s2 - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (value_valid && value_ready) begin
			func_s1  <= func;
			value_s1 <= value;
		end
		if (load_s2) begin
			seq_s2 <= enc.seq;
		end else if (out_beat) begin
			seq_s2 <= seq_s2 << BYTE_W;
		end
	end

	assign byte_valid = valid_s2;
	assign out_byte   = seq_s2[SEQ_W-1 -: BYTE_W];
	assign last_byte  = (cnt_s2 == CNT_W'(1));

endmodule

`default_nettype wire

>>> rtl/core/pve_encode.sv
// Combinational encoder: optional zigzag map, byte count and the left-aligned byte sequence.
`default_nettype none

module pve_encode (
	input  logic                          func,
	input  logic [pve_pkg::VALUE_W-1:0]   value,
	output pve_pkg::enc_t                 enc
);
	import pve_pkg::*;

	logic [VALUE_W-1:0]   mag;
	logic [VALUE_W-1:0]   v;
	logic [MAX_BYTES-2:0] big;
	logic [CNT_W-1:0]     n;
	logic [CNT_W-1:0]     top_sh;
	logic [CNT_W-1:0]     rest_sh;
	logic [BYTE_W-1:0]    ones;
	logic [BYTE_W-1:0]    mask;
	logic [BYTE_W-1:0]    header;
	logic [VALUE_W-1:0]   rest;
	logic [VALUE_W-1:0]   tail;

	// Zigzag: sign to bit 0, one's-complement magnitude above it.
	assign mag = value[VALUE_W-1] ? ~value : value;
	assign v   = func ? {mag[VALUE_W-2:0], value[VALUE_W-1]} : value;

	always_comb begin
		for (int k = 1; k < MAX_BYTES; k++) begin
			big[k-1] = |(v >> (GROUP_W * k));
		end
	end

	assign n       = CNT_W'(1) + CNT_W'($countones(big));
	assign top_sh  = CNT_W'(MAX_BYTES) - n;
	assign rest_sh = (n <= CNT_W'(BYTE_W)) ? (CNT_W'(BYTE_W) - n) : '0;
	assign ones    = {BYTE_W{1'b1}} << top_sh;
	assign mask    = {BYTE_W{1'b1}} >> n;
	assign header  = (v[BYTE_W-1:0] & mask) | ones;
	assign rest    = v >> rest_sh;
	assign tail    = rest << {top_sh, 3'b000};

	assign enc.seq    = {header, tail};
	assign enc.nbytes = n;

endmodule

`default_nettype wire

>>> rtl/core/pve_checker.sv
// Port-level checker for the prefix varint encoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module pve_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          value_valid,
	input  logic                          value_ready,
	input  logic                          byte_valid,
	input  logic                          byte_ready,
	input  logic [pve_pkg::BYTE_W-1:0]    out_byte,
	input  logic                          last_byte
);
	import pve_pkg::*;

	logic [1:0]        pending_q;
	logic              in_beat;
	logic              end_beat;
	logic [BYTE_W:0]   byte_data;

	assign in_beat   = value_valid && value_ready;
	assign end_beat  = byte_valid && byte_ready && last_byte;
	assign byte_data = {out_byte, last_byte};

	// Values accepted whose last byte has not gone out yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !end_beat) begin
			pending_q <= pending_q + 2'd1;
		end else if (!in_beat && end_beat) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`ASSERT_CLK(a_valid_holds, byte_valid && !byte_ready |=> byte_valid, "byte_valid fell in a stall")
	`ASSERT_CLK(a_byte_stable, byte_valid && !byte_ready |=> $stable(byte_data), "byte changed in a stall")
	`ASSERT_ALWAYS(a_no_orphan_byte, byte_valid |-> pending_q != 2'd0, "byte with no value pending")
	`ASSERT_CLK(a_ready_with_room, pending_q < 2'd2 |-> value_ready, "value_ready low with room")

endmodule

bind prefix_varint_encoder_unit pve_checker u_pve_checker (.*);

`default_nettype wire
